// ----- rtl/wags_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wags_pkg
// Shared widths, constants and control types for the wear-aware victim picker.
// ----------------------------------------------------------------------------
package wags_pkg;

    // Default sizes of the block table
    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int BLK_PAGES_DEF  = 64;

    // Field widths
    localparam int BIDX_W  = 10;
    localparam int PLANE_W = 3;
    localparam int VP_W    = 7;
    localparam int LIFE_W  = 17;
    localparam int THR_W   = 8;
    localparam int SEED_W  = 32;
    localparam int DRAW_W  = 16;
    localparam int MINV_W  = 10;
    localparam int CIDX_W  = 2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_WEAR_AGNOSTIC = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_LIFE_THR      = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_RANDOM_SEED   = 2'd2;

    // Reset values
    localparam logic [THR_W-1:0]  THR_RESET  = 8'd205;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;
    localparam logic [SEED_W-1:0] LFSR_TAPS  = 32'hD000_0001;

    // Input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PICK  = 1'b1;

    // One table row
    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic [VP_W-1:0]    vcount;
        logic [LIFE_W-1:0]  lifetime;
        logic               cleanable;
    } row_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;
        logic wr_entry;
        logic scan_init;
        logic scan_step;
        logic calc_rhs;
        logic pop_stack_rd;
        logic pop_tbl_rd;
        logic mul_life;
        logic draw;
        logic mul_draw;
        logic pop_drop;
        logic load_take;
        logic load_none;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
        logic scan_last;
        logic stack_empty;
        logic depth_one;
        logic agnostic;
        logic below_thr;
        logic draw_ok;
    } sts_t;

endpackage

// ----- rtl/wags_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wags_ctrl
// Sequencer: table clearing, scan, candidate pop loop and result hand-off.
// ----------------------------------------------------------------------------
module wags_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          in_command,
    output logic          m_tvalid,
    input  logic          m_tready,
    output wags_pkg::cmd_t cmd,
    input  wags_pkg::sts_t sts
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SCAN, ST_FLUSH, ST_CALC, ST_POP_RD, ST_POP_TBL,
        ST_POP_MUL, ST_POP_CMP, ST_POP_DRAW, ST_POP_TEST, ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   found_reg, found_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;
    logic   slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign slot_free = !m_tvalid_reg || m_tready;

    // Decode next state and commands
    always_comb begin
        state_next    = state_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (in_command == wags_pkg::CMD_PICK) begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end else begin
                        cmd.wr_entry = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                cmd.calc_rhs = 1'b1;
                if (sts.stack_empty) begin
                    found_next = 1'b0;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_POP_RD;
                end
            end
            ST_POP_RD: begin
                cmd.pop_stack_rd = 1'b1;
                state_next       = ST_POP_TBL;
            end
            ST_POP_TBL: begin
                cmd.pop_tbl_rd = 1'b1;
                state_next     = ST_POP_MUL;
            end
            ST_POP_MUL: begin
                cmd.mul_life = 1'b1;
                state_next   = ST_POP_CMP;
            end
            ST_POP_CMP: begin
                // Take at once unless wear limiting calls for a draw
                if (sts.depth_one || sts.agnostic || !sts.below_thr) begin
                    found_next = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    cmd.draw   = 1'b1;
                    state_next = ST_POP_DRAW;
                end
            end
            ST_POP_DRAW: begin
                cmd.mul_draw = 1'b1;
                state_next   = ST_POP_TEST;
            end
            ST_POP_TEST: begin
                if (sts.draw_ok) begin
                    found_next = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    cmd.pop_drop = 1'b1;
                    state_next   = ST_POP_RD;
                end
            end
            ST_FIN: begin
                // Hold until the output register can take the beat
                if (slot_free) begin
                    cmd.load_take = found_reg;
                    cmd.load_none = !found_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ----- rtl/wags_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wags_dp
// Datapath: block table, candidate stack, accumulators, LFSR and compares.
// ----------------------------------------------------------------------------
module wags_dp #(
    parameter int NUM_BLOCKS = wags_pkg::NUM_BLOCKS_DEF,
    parameter int BLK_PAGES  = wags_pkg::BLK_PAGES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wags_pkg::cmd_t                    cmd,
    output wags_pkg::sts_t                    sts,
    input  logic                              cfg_wr,
    input  logic [wags_pkg::CIDX_W-1:0]       cfg_index,
    input  logic [wags_pkg::SEED_W-1:0]       cfg_data,
    input  logic [wags_pkg::BIDX_W-1:0]       in_block_index,
    input  wags_pkg::row_t                    in_row,
    input  logic [wags_pkg::PLANE_W-1:0]      in_pick_plane,
    input  logic                              in_pick_any,
    output logic [wags_pkg::BIDX_W-1:0]       out_victim_block,
    output logic [wags_pkg::VP_W-1:0]         out_victim_vcount,
    output logic                              out_found
);

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int DEP_W  = IDX_W + 1;
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int SUM_W  = wags_pkg::LIFE_W + CNT_W;
    localparam int LB_W   = wags_pkg::LIFE_W + CNT_W;
    localparam int LHS_W  = LB_W + 8;
    localparam int RHS_W  = wags_pkg::THR_W + SUM_W;
    localparam int PROD_W = wags_pkg::DRAW_W + RHS_W;

    // Configuration and random source
    logic                          agnostic_reg;
    logic [wags_pkg::THR_W-1:0]    thr_reg;
    logic [wags_pkg::SEED_W-1:0]   lfsr_reg;
    logic [wags_pkg::SEED_W-1:0]   lfsr_next;

    // Memories
    wags_pkg::row_t                tbl_mem [NUM_BLOCKS];
    logic [IDX_W-1:0]              stk_mem [NUM_BLOCKS];
    wags_pkg::row_t                tbl_q;
    logic [IDX_W-1:0]              stk_q;

    // Scan and pop state
    logic [IDX_W-1:0]              clr_addr_reg;
    logic [IDX_W-1:0]              scan_addr_reg;
    logic [IDX_W-1:0]              scan_idx_reg;
    logic                          scan_vld_reg;
    logic [wags_pkg::PLANE_W-1:0]  plane_reg;
    logic                          any_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [DEP_W-1:0]              depth_reg;
    logic [DEP_W-1:0]              top_pos;
    logic [wags_pkg::MINV_W-1:0]   minv_reg;
    logic [RHS_W-1:0]              rhs_reg;
    logic [LB_W-1:0]               lbase_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic [IDX_W-1:0]              vic_idx_reg;
    logic [wags_pkg::VP_W-1:0]     vic_vp_reg;

    logic                          wr_in_range;
    logic                          rd_en;
    logic [IDX_W-1:0]              rd_addr;
    logic                          row_match;
    logic                          row_push;
    logic [LHS_W-1:0]              lhs;

    assign wr_in_range = 32'(in_block_index) < 32'(NUM_BLOCKS);
    assign top_pos     = depth_reg - 1'b1;
    assign lhs         = {lbase_reg, 8'd0};
    assign lfsr_next   = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? wags_pkg::LFSR_TAPS : '0);

    // Configuration registers and LFSR
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            agnostic_reg <= 1'b0;
            thr_reg      <= wags_pkg::THR_RESET;
            lfsr_reg     <= wags_pkg::SEED_RESET;
        end else if (cfg_wr) begin
            case (cfg_index)
                wags_pkg::CFG_WEAR_AGNOSTIC: agnostic_reg <= cfg_data[0];
                wags_pkg::CFG_LIFE_THR:      thr_reg <= cfg_data[wags_pkg::THR_W-1:0];
                wags_pkg::CFG_RANDOM_SEED: begin
                    lfsr_reg <= (cfg_data == '0) ? wags_pkg::SEED_RESET : cfg_data;
                end
                default: ;
            endcase
        end else if (cmd.draw) begin
            lfsr_reg <= lfsr_next;
        end
    end

    // Table: one write port for clearing and loading, one registered read
    assign rd_en   = cmd.scan_step || cmd.pop_tbl_rd;
    assign rd_addr = cmd.pop_tbl_rd ? stk_q : scan_addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            tbl_mem[clr_addr_reg] <= '0;
        end else if (cmd.wr_entry && wr_in_range) begin
            tbl_mem[IDX_W'(in_block_index)] <= in_row;
        end
        if (rd_en) begin
            tbl_q <= tbl_mem[rd_addr];
        end
    end

    // Candidate stack
    always_ff @(posedge aclk) begin
        if (row_push) begin
            stk_mem[depth_reg[IDX_W-1:0]] <= scan_idx_reg;
        end
        if (cmd.pop_stack_rd) begin
            stk_q <= stk_mem[top_pos[IDX_W-1:0]];
        end
    end

    // Eligibility of the row returned by the scan
    assign row_match = any_reg || (tbl_q.plane == plane_reg);
    assign row_push  = scan_vld_reg && row_match && (tbl_q.lifetime != '0)
                       && tbl_q.cleanable
                       && (wags_pkg::MINV_W'(tbl_q.vcount) <= minv_reg);

    // Clearing pass and scan counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            scan_addr_reg <= '0;
            scan_vld_reg  <= 1'b0;
            depth_reg     <= '0;
        end else begin
            scan_vld_reg <= cmd.scan_step;
            if (cmd.clear_step) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.scan_init) begin
                scan_addr_reg <= '0;
                depth_reg     <= '0;
            end else begin
                if (cmd.scan_step) begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
                if (row_push) begin
                    depth_reg <= depth_reg + 1'b1;
                end else if (cmd.pop_drop) begin
                    depth_reg <= top_pos;
                end
            end
        end
    end

    // Accumulate lifetime sum and count, track running minimum
    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_addr_reg;
        if (cmd.scan_init) begin
            plane_reg <= in_pick_plane;
            any_reg   <= in_pick_any;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            minv_reg  <= wags_pkg::MINV_W'(BLK_PAGES - 1);
        end else if (scan_vld_reg) begin
            if (row_match) begin
                sum_reg <= sum_reg + SUM_W'(tbl_q.lifetime);
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (row_push) begin
                minv_reg <= wags_pkg::MINV_W'(tbl_q.vcount);
            end
        end
    end

    // Wear arithmetic: threshold product, life product, draw product
    always_ff @(posedge aclk) begin
        if (cmd.calc_rhs) begin
            rhs_reg <= RHS_W'(thr_reg * sum_reg);
        end
        if (cmd.pop_tbl_rd) begin
            vic_idx_reg <= stk_q;
        end
        if (cmd.mul_life) begin
            lbase_reg  <= LB_W'(tbl_q.lifetime * cnt_reg);
            vic_vp_reg <= tbl_q.vcount;
        end
        if (cmd.mul_draw) begin
            prod_reg <= PROD_W'(lfsr_reg[wags_pkg::SEED_W-1 -: wags_pkg::DRAW_W] * rhs_reg);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.load_take) begin
            out_victim_block  <= wags_pkg::BIDX_W'(vic_idx_reg);
            out_victim_vcount <= vic_vp_reg;
            out_found         <= 1'b1;
        end else if (cmd.load_none) begin
            out_victim_block  <= '0;
            out_victim_vcount <= '0;
            out_found         <= 1'b0;
        end
    end

    // Status
    assign sts.clear_last  = (clr_addr_reg == IDX_W'(NUM_BLOCKS - 1));
    assign sts.scan_last   = (scan_addr_reg == IDX_W'(NUM_BLOCKS - 1));
    assign sts.stack_empty = (depth_reg == '0);
    assign sts.depth_one   = (depth_reg == DEP_W'(1));
    assign sts.agnostic    = agnostic_reg;
    assign sts.below_thr   = (lhs < rhs_reg);
    assign sts.draw_ok     = (prod_reg < {lhs, 16'd0});

endmodule

// ----- rtl/wear_aware_gc_victim_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wear_aware_gc_victim_select
// Greedy garbage-collection victim picker with lifetime-based rate limiting.
// ----------------------------------------------------------------------------
// Channel | Dir | Beat contents
// s_      | in  | tuser: command; tdata: block_index, entry_plane,
//         |     |   entry valid count, entry_lifetime, entry_cleanable,
//         |     |   pick_plane, pick_any_plane
// m_      | out | tuser: found; tdata: victim_block, victim valid count
// cfg_    | in  | cfg_index, cfg_data (one register write per beat)
//
// Writes are taken in the idle state. A pick scans the table once, forms
// the threshold product, then per popped candidate reads the stack and the
// table, forms the life product and compares, adding an LFSR draw and test
// under wear limiting, and hands off the result. After reset the table is
// cleared one row a cycle with s_tready low; cfg_ beats are always taken.
// A finished result waits in the output register while the next beat is taken.
module wear_aware_gc_victim_select #(
    parameter int NUM_BLOCKS = wags_pkg::NUM_BLOCKS_DEF,
    parameter int BLK_PAGES  = wags_pkg::BLK_PAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] block_index, [12:10] entry_plane, [19:13] entry valid count,
    // [36:20] entry_lifetime, [37] entry_cleanable, [40:38] pick_plane,
    // [41] pick_any_plane
    input  logic [47:0] s_tdata,
    // [0] command
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [9:0] victim_block, [16:10] victim valid count
    output logic [23:0] m_tdata,
    // [0] found
    output logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    wags_pkg::cmd_t cmd;
    wags_pkg::sts_t sts;
    wags_pkg::row_t in_row;
    logic [wags_pkg::BIDX_W-1:0] victim_block;
    logic [wags_pkg::VP_W-1:0]   victim_vp;
    logic                        found;

    assign cfg_ready = 1'b1;

    // Unpack the input beat
    assign in_row.plane     = s_tdata[12:10];
    assign in_row.vcount    = s_tdata[19:13];
    assign in_row.lifetime  = s_tdata[36:20];
    assign in_row.cleanable = s_tdata[37];

    // Pack the result beat
    assign m_tdata = {7'd0, victim_vp, victim_block};
    assign m_tuser = found;

    wags_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_command (s_tuser[0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cmd        (cmd),
        .sts        (sts)
    );

    wags_dp #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .BLK_PAGES  (BLK_PAGES)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_wr            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_block_index    (s_tdata[9:0]),
        .in_row            (in_row),
        .in_pick_plane     (s_tdata[40:38]),
        .in_pick_any       (s_tdata[41]),
        .out_victim_block  (victim_block),
        .out_victim_vcount (victim_vp),
        .out_found         (found)
    );

endmodule

// ----- test/wear_aware_gc_victim_select_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wear_aware_gc_victim_select_tb
// Self-checking bench for the victim picker. Table writes and picks are
// driven on the input stream, a shadow table and LFSR predict each pick
// result, and the result stream is compared beat by beat. Phases vary the
// registers and the idling of both sides.
// ----------------------------------------------------------------------------
module wear_aware_gc_victim_select_tb;

    localparam int TBL_N = 1024;
    localparam int MINV0 = 63;

    // lowest member last, so bits [41:0] match the tdata layout
    typedef struct packed {
        logic                         cmd;
        logic                         any;
        logic [wags_pkg::PLANE_W-1:0] pplane;
        logic                         clean;
        logic [wags_pkg::LIFE_W-1:0]  life;
        logic [wags_pkg::VP_W-1:0]    vp;
        logic [wags_pkg::PLANE_W-1:0] plane;
        logic [wags_pkg::BIDX_W-1:0]  idx;
    } beat_t;

    typedef struct packed {
        logic [wags_pkg::BIDX_W-1:0] blk;
        logic [wags_pkg::VP_W-1:0]   vp;
        logic                        found;
    } victim_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0, s_tready;
    logic [47:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid, m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    wear_aware_gc_victim_select DUT (.*);

    // shadow state
    logic [wags_pkg::PLANE_W-1:0] sh_plane [TBL_N];
    logic [wags_pkg::VP_W-1:0]    sh_vp    [TBL_N];
    logic [wags_pkg::LIFE_W-1:0]  sh_life  [TBL_N];
    logic                         sh_clean [TBL_N];
    logic                         sh_agn = 1'b0;
    logic [wags_pkg::THR_W-1:0]   sh_thr = wags_pkg::THR_RESET;
    logic [wags_pkg::SEED_W-1:0]  sh_lfsr = wags_pkg::SEED_RESET;

    beat_t   pending_beats[$];
    victim_t expected_victims[$];
    int      send_idle_pct = 0, recv_stall_pct = 0;
    bit      failed = 0;

    initial forever #10 aclk = ~aclk;

    function automatic logic [wags_pkg::DRAW_W-1:0] next_draw();
        logic lsb;
        lsb = sh_lfsr[0];
        sh_lfsr = sh_lfsr >> 1;
        if (lsb) sh_lfsr = sh_lfsr ^ wags_pkg::LFSR_TAPS;
        return sh_lfsr[31:16];
    endfunction

    // apply one accepted beat to the shadow table, queue the predicted victim
    function automatic void predict_victim(beat_t b);
        logic [63:0] sum, cnt, lhs, rhs, r;
        int stack[$];
        int minv, c;
        victim_t v;
        if (b.cmd == wags_pkg::CMD_WRITE) begin
            sh_plane[b.idx] = b.plane;
            sh_vp[b.idx] = b.vp;
            sh_life[b.idx] = b.life;
            sh_clean[b.idx] = b.clean;
            return;
        end
        sum = 0;
        cnt = 0;
        minv = MINV0;
        v = '0;
        for (int i = 0; i < TBL_N; i++) begin
            if (b.any || sh_plane[i] == b.pplane) begin
                sum += 64'(sh_life[i]);
                cnt++;
                if (sh_life[i] != 0 && sh_clean[i] && int'(sh_vp[i]) <= minv) begin
                    stack.push_back(i);
                    minv = int'(sh_vp[i]);
                end
            end
        end
        while (stack.size() > 0) begin
            c = stack[$];
            if (stack.size() == 1 || sh_agn) begin
                v = '{c[wags_pkg::BIDX_W-1:0], sh_vp[c], 1'b1};
                break;
            end
            lhs = 64'(sh_life[c]) * 256 * cnt;
            rhs = 64'(sh_thr) * sum;
            if (!(lhs < rhs)) begin
                v = '{c[wags_pkg::BIDX_W-1:0], sh_vp[c], 1'b1};
                break;
            end
            r = 64'(next_draw());
            if (r * rhs < lhs * 65536) begin
                v = '{c[wags_pkg::BIDX_W-1:0], sh_vp[c], 1'b1};
                break;
            end
            void'(stack.pop_back());
        end
        expected_victims.push_back(v);
    endfunction

    // drive the input stream from the pending queue
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_victim(beat_t'({s_tuser, s_tdata[41:0]}));
            if (!(s_tvalid && !s_tready)) begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    beat_t b;
                    b = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= b.cmd;
                    s_tdata  <= {6'd0, b[41:0]};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // check result beats, stall at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                victim_t got, exp_v;
                got = '{m_tdata[9:0], m_tdata[16:10], m_tuser[0]};
                if (expected_victims.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                    failed = 1;
                end else begin
                    exp_v = expected_victims.pop_front();
                    if (got.blk !== exp_v.blk)
                        $display("%0t: victim_block expected %0d got %0d", $time, exp_v.blk,
                                 got.blk);
                    if (got.vp !== exp_v.vp)
                        $display("%0t: victim valid count expected %0d got %0d", $time,
                                 exp_v.vp, got.vp);
                    if (got.found !== exp_v.found)
                        $display("%0t: found expected %0d got %0d", $time, exp_v.found,
                                 got.found);
                    if (got !== exp_v) failed = 1;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic beat_t wr_beat(int idx, int pl, int vp, int life, int cl);
        beat_t b;
        b = beat_t'($urandom());
        b.cmd = wags_pkg::CMD_WRITE;
        b.idx = wags_pkg::BIDX_W'(idx);
        b.plane = wags_pkg::PLANE_W'(pl);
        b.vp = wags_pkg::VP_W'(vp);
        b.life = wags_pkg::LIFE_W'(life);
        b.clean = cl[0];
        return b;
    endfunction

    function automatic beat_t pick_beat(int pl, int any);
        beat_t b;
        b = beat_t'($urandom());
        b.cmd = wags_pkg::CMD_PICK;
        b.pplane = wags_pkg::PLANE_W'(pl);
        b.any = any[0];
        return b;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            wags_pkg::CFG_WEAR_AGNOSTIC: sh_agn = val[0];
            wags_pkg::CFG_LIFE_THR:      sh_thr = val[wags_pkg::THR_W-1:0];
            default:                     sh_lfsr = (val == 0) ? wags_pkg::SEED_RESET : val;
        endcase
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || s_tvalid || expected_victims.size() > 0)
            @(posedge aclk);
        repeat (TBL_N + 50) @(posedge aclk);
    endtask

    // mostly well-formed traffic: writes mostly into a small window, picks mixed in at random
    task automatic queue_random(int n);
        int base;
        base = $urandom_range(TBL_N - 40);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(4) == 0) begin
                pending_beats.push_back(pick_beat($urandom_range(7),
                                                  int'($urandom_range(3) == 0)));
            end else if ($urandom_range(9) == 0) begin
                pending_beats.push_back(wr_beat($urandom_range(TBL_N - 1), $urandom_range(7),
                                                $urandom_range(127), $urandom(),
                                                $urandom_range(1)));
            end else begin
                pending_beats.push_back(wr_beat(base + $urandom_range(39), $urandom_range(3),
                                                $urandom_range(64),
                                                $urandom_range(3) == 0 ? $urandom_range(131071)
                                                : $urandom_range(2000),
                                                int'($urandom_range(4) != 0)));
            end
        end
    endtask

    initial begin
        foreach (sh_plane[i]) begin
            sh_plane[i] = 0;
            sh_vp[i] = 0;
            sh_life[i] = 0;
            sh_clean[i] = 0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, extremes, ties, special cases
        pending_beats.push_back(pick_beat(0, 0));
        pending_beats.push_back(pick_beat(7, 1));
        pending_beats.push_back(wr_beat(1023, 7, 0, 131071, 1));
        pending_beats.push_back(wr_beat(0, 7, 64, 1, 1));
        pending_beats.push_back(wr_beat(5, 7, 127, 500, 1));
        pending_beats.push_back(wr_beat(6, 7, 10, 0, 1));
        pending_beats.push_back(wr_beat(7, 7, 10, 50, 0));
        pending_beats.push_back(wr_beat(8, 7, 10, 3, 1));
        pending_beats.push_back(wr_beat(9, 7, 10, 2, 1));
        pending_beats.push_back(wr_beat(10, 2, 5, 9, 1));
        pending_beats.push_back(pick_beat(7, 0));
        pending_beats.push_back(pick_beat(7, 1));
        pending_beats.push_back(pick_beat(2, 0));
        pending_beats.push_back(pick_beat(4, 0));
        drain();
        // zero threshold, zero seed
        write_reg(wags_pkg::CFG_LIFE_THR, 0);
        write_reg(wags_pkg::CFG_RANDOM_SEED, 0);
        pending_beats.push_back(pick_beat(7, 0));
        drain();
        write_reg(wags_pkg::CFG_WEAR_AGNOSTIC, 1);
        write_reg(wags_pkg::CFG_LIFE_THR, 255);
        pending_beats.push_back(pick_beat(7, 0));
        pending_beats.push_back(pick_beat(0, 1));
        drain();

        // random phases with various settings and idling
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(wags_pkg::CFG_WEAR_AGNOSTIC, 32'(ph == 4));
            write_reg(wags_pkg::CFG_LIFE_THR, ph == 0 ? 255 : $urandom_range(255));
            write_reg(wags_pkg::CFG_RANDOM_SEED, ph == 1 ? 32'hFFFF_FFFF : $urandom());
            send_idle_pct  = (ph == 1 || ph == 3) ? 71 : 0;
            recv_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 33 : 0;
            if (ph == 3) send_idle_pct = 33;
            queue_random(34);
            drain();
        end

        if (!failed) begin
            $display("PASS wear_aware_gc_victim_select");
        end else begin
            $display("FAIL wear_aware_gc_victim_select");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("FAIL wear_aware_gc_victim_select");
        $finish;
    end
endmodule
